// ===== sv/dlaq_pkg.sv =====
//------------------------------------------------------------------------------
// dlaq_pkg: shared types and constants for the delta list alarm queue
// Widths, command and result codes used by the queue logic.
//------------------------------------------------------------------------------
`default_nettype none
package dlaq_pkg;
    localparam int NUM_ALARMS = 16;
    localparam int TICK_WIDTH = 32;
    localparam int ID_W       = $clog2(NUM_ALARMS);
    localparam int LINK_W     = ID_W + 1;
    localparam int MAX_OUT    = 16;
    localparam logic [LINK_W-1:0] NONE_LINK = LINK_W'(NUM_ALARMS);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ADD    = 2'd0;
    localparam t_cmd CMD_CANCEL = 2'd1;
    localparam t_cmd CMD_TICK   = 2'd2;
    localparam t_cmd CMD_QUERY  = 2'd3;

    typedef logic [2:0] t_kind;
    localparam t_kind K_TRIGGER = 3'd0;
    localparam t_kind K_READY   = 3'd1;
    localparam t_kind K_QUERY   = 3'd2;
    localparam t_kind K_DONE    = 3'd3;
    localparam t_kind K_REJECT  = 3'd4;
endpackage
`default_nettype wire

// ===== sv/delta_list_alarm_queue_top.sv =====
//------------------------------------------------------------------------------
// delta_list_alarm_queue_top: sorted delta list timer queue
// Add, cancel, tick and query on up to sixteen alarms, walked link by link.
//------------------------------------------------------------------------------
// Channel | Direction | Handshake
// command | in        | i_start && !o_busy
// result  | out       | o_valid high for a single cycle per beat, no stall
// An add, cancel or query that needs the list walks it one link per cycle;
// a cancel then folds its delta into the successor in the S_CAN_FIX state.
// A tick shows one beat per expired alarm, up to MAX_OUT, or a done beat if none expire.
// Reset empties the list and clears all ready marks at once.
// Results cannot be stalled; busy stays high until the last beat is shown.
`default_nettype none
module delta_list_alarm_queue_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    output logic                               o_busy,
    input  wire logic [1:0]                    i_command,
    input  wire logic [3:0]                    i_alarm_id,
    input  wire logic [31:0]                   i_delay_ticks,
    input  wire logic                          i_fire_async,
    output logic                               o_valid,
    output logic [2:0]                         o_kind,
    output logic [3:0]                         o_which_alarm,
    output logic [31:0]                        o_remaining,
    output logic                               o_last
);
    import dlaq_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_ADD, S_CAN, S_CAN_FIX, S_TICK, S_QRY} t_state;

    logic [TICK_WIDTH-1:0] r_delta [NUM_ALARMS];
    logic [LINK_W-1:0]     r_next  [NUM_ALARMS];
    logic [NUM_ALARMS-1:0] r_queued, r_async, r_ready;
    logic [LINK_W-1:0]     r_head;

    t_state                r_state;
    logic [ID_W-1:0]       r_id;
    logic [TICK_WIDTH-1:0] r_acc;
    logic                  r_as;
    logic [LINK_W-1:0]     r_prev, r_cur;
    logic [LINK_W:0]       r_guard;
    logic [LINK_W:0]       r_nout;

    logic                  cur_ok;
    logic [ID_W-1:0]       cur_i, prev_i;
    logic [TICK_WIDTH-1:0] cur_d;
    logic [TICK_WIDTH-1:0] sat_d;
    logic [TICK_WIDTH:0]   diff;
    logic [TICK_WIDTH-1:0] acc_sum;

    assign cur_ok = (r_cur < NONE_LINK);
    assign cur_i  = r_cur[ID_W-1:0];
    assign prev_i = r_prev[ID_W-1:0];
    assign cur_d  = r_delta[cur_i];
    // One shared subtractor: compare and difference of list delta and carried delay.
    assign diff   = {1'b0, r_acc} - {1'b0, cur_d};
    assign acc_sum = r_acc + cur_d;
    assign sat_d  = (TICK_WIDTH >= 32) ? TICK_WIDTH'(i_delay_ticks)
                  : ((i_delay_ticks > 32'({TICK_WIDTH{1'b1}})) ? {TICK_WIDTH{1'b1}}
                     : TICK_WIDTH'(i_delay_ticks));

    assign o_busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        o_valid <= 1'b0;
        o_last  <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_queued <= '0;
            r_ready  <= '0;
            r_head   <= NONE_LINK;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_id    <= i_alarm_id[ID_W-1:0];
                        r_as    <= i_fire_async;
                        r_acc   <= sat_d;
                        r_prev  <= NONE_LINK;
                        r_cur   <= r_head;
                        r_guard <= '0;
                        r_nout  <= '0;
                        o_which_alarm <= i_alarm_id;
                        o_remaining   <= '0;
                        if (i_command == CMD_TICK) begin
                            if (r_head < NONE_LINK && r_delta[r_head[ID_W-1:0]] != '0)
                                r_delta[r_head[ID_W-1:0]] <= r_delta[r_head[ID_W-1:0]] - 1'b1;
                            r_state <= S_TICK;
                        end else if (32'(i_alarm_id) >= 32'(NUM_ALARMS)) begin
                            o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_REJECT;
                        end else if (i_command == CMD_ADD) begin
                            if (r_queued[i_alarm_id[ID_W-1:0]]) begin
                                o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_REJECT;
                            end else if (sat_d == '0) begin
                                r_ready[i_alarm_id[ID_W-1:0]] <= 1'b1;
                                o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_READY;
                            end else begin
                                r_state <= S_ADD;
                            end
                        end else if (i_command == CMD_CANCEL) begin
                            if (r_queued[i_alarm_id[ID_W-1:0]]) begin
                                r_state <= S_CAN;
                            end else begin
                                r_ready[i_alarm_id[ID_W-1:0]] <= 1'b0;
                                o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_DONE;
                            end
                        end else begin
                            r_acc   <= '0;
                            r_state <= S_QRY;
                        end
                    end
                end
                S_ADD: begin
                    if (cur_ok && r_guard < (LINK_W+1)'(NUM_ALARMS) && !diff[TICK_WIDTH]
                        && diff[TICK_WIDTH-1:0] != '0) begin
                        r_acc   <= diff[TICK_WIDTH-1:0];
                        r_prev  <= r_cur;
                        r_cur   <= r_next[cur_i];
                        r_guard <= r_guard + 1'b1;
                    end else begin
                        r_next[r_id]  <= cur_ok ? r_cur : NONE_LINK;
                        if (r_prev < NONE_LINK) r_next[prev_i] <= LINK_W'(r_id);
                        else                    r_head <= LINK_W'(r_id);
                        r_delta[r_id] <= r_acc;
                        if (cur_ok) r_delta[cur_i] <= cur_d - r_acc;
                        r_queued[r_id] <= 1'b1;
                        r_async[r_id]  <= r_as;
                        r_ready[r_id]  <= 1'b0;
                        o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_DONE;
                        r_state <= S_IDLE;
                    end
                end
                S_CAN: begin
                    if (cur_ok && cur_i != r_id && r_guard < (LINK_W+1)'(NUM_ALARMS)) begin
                        r_prev  <= r_cur;
                        r_cur   <= r_next[cur_i];
                        r_guard <= r_guard + 1'b1;
                    end else begin
                        if (cur_ok && cur_i == r_id) begin
                            if (r_prev < NONE_LINK) r_next[prev_i] <= r_next[r_id];
                            else                    r_head <= r_next[r_id];
                            r_cur <= r_next[r_id];
                            r_acc <= r_delta[r_id];
                        end else begin
                            r_cur <= NONE_LINK;
                        end
                        r_queued[r_id] <= 1'b0;
                        r_ready[r_id]  <= 1'b0;
                        r_state <= S_CAN_FIX;
                    end
                end
                S_CAN_FIX: begin
                    // Fold the removed delta into the successor.
                    if (cur_ok) r_delta[cur_i] <= acc_sum;
                    o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_DONE;
                    r_state <= S_IDLE;
                end
                S_TICK: begin
                    if (cur_ok && cur_d == '0 && r_nout < (LINK_W+1)'(MAX_OUT)) begin
                        r_head <= r_next[cur_i];
                        r_cur  <= r_next[cur_i];
                        r_queued[cur_i] <= 1'b0;
                        if (!r_async[cur_i]) r_ready[cur_i] <= 1'b1;
                        o_kind        <= r_async[cur_i] ? K_TRIGGER : K_READY;
                        o_which_alarm <= 4'(cur_i);
                        o_valid <= 1'b1;
                        r_nout  <= r_nout + 1'b1;
                        if (!(r_next[cur_i] < NONE_LINK
                              && r_delta[r_next[cur_i][ID_W-1:0]] == '0
                              && r_nout + 1'b1 < (LINK_W+1)'(MAX_OUT))) begin
                            o_last  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end else begin
                        o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_DONE;
                        o_which_alarm <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_QRY: begin
                    if (cur_ok && r_guard < (LINK_W+1)'(NUM_ALARMS)) begin
                        if (cur_i == r_id) begin
                            // The answer saturates when the tick count is wider than the port.
                            o_remaining <= ((TICK_WIDTH+32)'(acc_sum)
                                            > (TICK_WIDTH+32)'(32'hFFFF_FFFF))
                                           ? 32'hFFFF_FFFF : 32'(acc_sum);
                            o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_QUERY;
                            r_state <= S_IDLE;
                        end else begin
                            r_acc   <= acc_sum;
                            r_cur   <= r_next[cur_i];
                            r_guard <= r_guard + 1'b1;
                        end
                    end else begin
                        o_remaining <= '0;
                        o_valid <= 1'b1; o_last <= 1'b1; o_kind <= K_QUERY;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_last_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid) else $error("last without valid");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> r_state == S_IDLE) else $error("last while still busy");
    a_ready_not_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> ((r_ready & r_queued) == '0))
        else $error("alarm both ready and queued");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_valid || o_busy)) else $error("command dropped");
`endif
endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
//------------------------------------------------------------------------------
// testbench: self-checking bench for the delta list alarm queue
// Drives add, cancel, tick and query commands with random sender gaps, keeps a
// behavioral copy of the sorted delta list and checks every result beat.
//------------------------------------------------------------------------------
module testbench;
    import dlaq_pkg::*;

    typedef struct packed {
        t_cmd        cmd;
        logic [3:0]  id;
        logic [31:0] delay;
        logic        fire_async;
    } t_request;

    typedef struct packed {
        t_kind       kind;
        logic [3:0]  which;
        logic [31:0] remaining;
        logic        last;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_start = 1'b0;
    logic [1:0]  i_command = '0;
    logic [3:0]  i_alarm_id = '0;
    logic [31:0] i_delay_ticks = '0;
    logic        i_fire_async = 1'b0;
    logic        o_busy, o_valid, o_last;
    logic [2:0]  o_kind;
    logic [3:0]  o_which_alarm;
    logic [31:0] o_remaining;

    delta_list_alarm_queue_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_command(i_command), .i_alarm_id(i_alarm_id),
        .i_delay_ticks(i_delay_ticks), .i_fire_async(i_fire_async),
        .o_valid(o_valid), .o_kind(o_kind), .o_which_alarm(o_which_alarm),
        .o_remaining(o_remaining), .o_last(o_last)
    );

    always #6 i_clk = ~i_clk;

    // Behavioral copy of the alarm list.
    logic [31:0]       alarm_delta [NUM_ALARMS];
    logic [LINK_W-1:0] alarm_next  [NUM_ALARMS];
    logic              alarm_queued[NUM_ALARMS];
    logic              alarm_async [NUM_ALARMS];
    logic              alarm_ready [NUM_ALARMS];
    logic [LINK_W-1:0] list_head;

    t_request pending_reqs[$];
    t_answer  expected_beats[$];
    int       idle_pct = 0;
    int       hold_until_drained = 0;
    int       error_count = 0;
    int       cycle_count = 0;
    bit       stimulus_done = 0;

    function automatic void push_beat(t_kind k, logic [3:0] w, logic [31:0] r);
        t_answer a;
        a.kind = k; a.which = w; a.remaining = r; a.last = 1'b0;
        expected_beats.push_back(a);
    endfunction

    function automatic void predict_command(t_request rq);
        logic [LINK_W-1:0] prev, cur, nx;
        logic [31:0] d, sum, ans;
        int guard, n;
        t_answer a;
        prev = NONE_LINK; cur = list_head; guard = 0; n = 0;
        if (rq.cmd == CMD_TICK) begin
            cur = list_head;
            if (cur != NONE_LINK && alarm_delta[cur[ID_W-1:0]] != 0)
                alarm_delta[cur[ID_W-1:0]] = alarm_delta[cur[ID_W-1:0]] - 1;
            while (cur != NONE_LINK && alarm_delta[cur[ID_W-1:0]] == 0 && n < MAX_OUT) begin
                list_head = alarm_next[cur[ID_W-1:0]];
                alarm_queued[cur[ID_W-1:0]] = 1'b0;
                if (alarm_async[cur[ID_W-1:0]]) begin
                    push_beat(K_TRIGGER, cur[3:0], '0);
                end else begin
                    alarm_ready[cur[ID_W-1:0]] = 1'b1;
                    push_beat(K_READY, cur[3:0], '0);
                end
                n++;
                cur = list_head;
            end
            if (n == 0) push_beat(K_DONE, 4'd0, '0);
        end else if (rq.cmd == CMD_ADD) begin
            d = rq.delay;
            if (alarm_queued[rq.id]) begin
                push_beat(K_REJECT, rq.id, '0);
            end else if (d == 0) begin
                alarm_ready[rq.id] = 1'b1;
                push_beat(K_READY, rq.id, '0);
            end else begin
                while (cur != NONE_LINK && guard < NUM_ALARMS
                       && alarm_delta[cur[ID_W-1:0]] < d) begin
                    d = d - alarm_delta[cur[ID_W-1:0]];
                    prev = cur;
                    cur = alarm_next[cur[ID_W-1:0]];
                    guard++;
                end
                alarm_next[rq.id] = cur;
                if (prev != NONE_LINK) alarm_next[prev[ID_W-1:0]] = {1'b0, rq.id};
                else list_head = {1'b0, rq.id};
                alarm_delta[rq.id] = d;
                if (cur != NONE_LINK)
                    alarm_delta[cur[ID_W-1:0]] = alarm_delta[cur[ID_W-1:0]] - d;
                alarm_queued[rq.id] = 1'b1;
                alarm_async[rq.id] = rq.fire_async;
                alarm_ready[rq.id] = 1'b0;
                push_beat(K_DONE, rq.id, '0);
            end
        end else if (rq.cmd == CMD_CANCEL) begin
            if (alarm_queued[rq.id]) begin
                while (cur != NONE_LINK && cur != {1'b0, rq.id} && guard < NUM_ALARMS) begin
                    prev = cur;
                    cur = alarm_next[cur[ID_W-1:0]];
                    guard++;
                end
                if (cur == {1'b0, rq.id}) begin
                    nx = alarm_next[rq.id];
                    if (prev != NONE_LINK) alarm_next[prev[ID_W-1:0]] = nx;
                    else list_head = nx;
                    if (nx != NONE_LINK)
                        alarm_delta[nx[ID_W-1:0]] = alarm_delta[nx[ID_W-1:0]]
                                                    + alarm_delta[rq.id];
                end
                alarm_queued[rq.id] = 1'b0;
            end
            alarm_ready[rq.id] = 1'b0;
            push_beat(K_DONE, rq.id, '0);
        end else begin
            sum = '0; ans = '0;
            while (cur != NONE_LINK && guard < NUM_ALARMS) begin
                sum = sum + alarm_delta[cur[ID_W-1:0]];
                if (cur == {1'b0, rq.id}) begin
                    ans = sum;
                    break;
                end
                cur = alarm_next[cur[ID_W-1:0]];
                guard++;
            end
            push_beat(K_QUERY, rq.id, ans);
        end
        a = expected_beats.pop_back();
        a.last = 1'b1;
        expected_beats.push_back(a);
    endfunction

    // Driver: predicts each accepted command and holds start while the DUT is busy.
    always @(posedge i_clk) begin
        t_request rq;
        cycle_count <= cycle_count + 1;
        if (i_rst_n) begin
            if (i_start && !o_busy) predict_command({i_command, i_alarm_id,
                                                      i_delay_ticks, i_fire_async});
            if (!(i_start && o_busy)) begin
                if (pending_reqs.size() != 0 && hold_until_drained != 0) begin
                    i_start <= 1'b0;
                    if (expected_beats.size() == 0 && !(i_start && !o_busy))
                        hold_until_drained <= 0;
                end else if (pending_reqs.size() != 0 &&
                             $urandom_range(99, 0) >= idle_pct) begin
                    rq = pending_reqs.pop_front();
                    i_start       <= 1'b1;
                    i_command     <= rq.cmd;
                    i_alarm_id    <= rq.id;
                    i_delay_ticks <= rq.delay;
                    i_fire_async  <= rq.fire_async;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // Monitor: results cannot be stalled, so every strobed beat is checked.
    always @(posedge i_clk) begin
        t_answer exp_a;
        if (i_rst_n && o_valid) begin
            if (expected_beats.size() == 0) begin
                $display("%0t unexpected beat: kind %0d alarm %0d rem %0d last %0b",
                         $time, o_kind, o_which_alarm, o_remaining, o_last);
                error_count++;
            end else begin
                exp_a = expected_beats.pop_front();
                if (exp_a.kind != o_kind || exp_a.which != o_which_alarm ||
                    exp_a.remaining != o_remaining || exp_a.last != o_last) begin
                    $display("%0t mismatch: expected kind %0d alarm %0d rem %0d last %0b",
                             $time, exp_a.kind, exp_a.which, exp_a.remaining, exp_a.last);
                    $display("%0t           actual   kind %0d alarm %0d rem %0d last %0b",
                             $time, o_kind, o_which_alarm, o_remaining, o_last);
                    error_count++;
                end
            end
        end
    end

    function automatic t_request make_req(t_cmd c, logic [3:0] id, logic [31:0] d,
                                          logic fa);
        t_request rq;
        rq.cmd = c; rq.id = id; rq.delay = d; rq.fire_async = fa;
        return rq;
    endfunction

    // Mostly small delays so that ticks expire alarms often; some wide ones.
    function automatic logic [31:0] pick_delay();
        int sel;
        sel = $urandom_range(99, 0);
        if (sel < 8) return '0;
        if (sel < 75) return $urandom_range(6, 1);
        if (sel < 88) return $urandom_range(40, 1);
        if (sel < 94) return 32'hFFFF_FFFF - $urandom_range(3, 0);
        return $urandom;
    endfunction

    function automatic t_request random_req();
        int sel;
        logic [3:0] rid;
        logic       rfa;
        sel = $urandom_range(99, 0);
        rid = 4'($urandom_range(15, 0));
        rfa = 1'($urandom_range(1, 0));
        if (sel < 38)
            return make_req(CMD_ADD, rid, pick_delay(), rfa);
        if (sel < 50)
            return make_req(CMD_CANCEL, rid, $urandom, rfa);
        if (sel < 82)
            return make_req(CMD_TICK, rid, $urandom, rfa);
        return make_req(CMD_QUERY, rid, $urandom, rfa);
    endfunction

    task automatic drain_queue();
        while (pending_reqs.size() != 0 || i_start) @(posedge i_clk);
    endtask

    initial begin
        int k;
        for (k = 0; k < NUM_ALARMS; k++) begin
            alarm_delta[k] = '0; alarm_next[k] = NONE_LINK;
            alarm_queued[k] = 1'b0; alarm_async[k] = 1'b0; alarm_ready[k] = 1'b0;
        end
        list_head = NONE_LINK;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty tick, zero delay, extremes, duplicate add, cancels.
        pending_reqs.push_back(make_req(CMD_TICK, 4'd0, '0, 1'b0));
        pending_reqs.push_back(make_req(CMD_QUERY, 4'd15, '0, 1'b0));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd3, '0, 1'b1));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd15, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd0, 32'd2, 1'b1));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd5, 32'd2, 1'b0));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd7, 32'd1, 1'b0));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd7, 32'd9, 1'b1));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd10, 32'h5555_AAAA, 1'b0));
        pending_reqs.push_back(make_req(CMD_QUERY, 4'd15, '0, 1'b0));
        pending_reqs.push_back(make_req(CMD_QUERY, 4'd5, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(make_req(CMD_CANCEL, 4'd10, '0, 1'b0));
        pending_reqs.push_back(make_req(CMD_CANCEL, 4'd3, '0, 1'b0));
        pending_reqs.push_back(make_req(CMD_CANCEL, 4'd9, '0, 1'b0));
        pending_reqs.push_back(make_req(CMD_TICK, 4'd15, 32'hFFFF_FFFF, 1'b1));
        pending_reqs.push_back(make_req(CMD_TICK, 4'd0, '0, 1'b0));
        // Sixteen alarms at the same delay expire together in one tick.
        for (k = 0; k < NUM_ALARMS; k++)
            if (k != 15) pending_reqs.push_back(make_req(CMD_ADD, k[3:0], 32'd1, k[0]));
        pending_reqs.push_back(make_req(CMD_CANCEL, 4'd15, '0, 1'b0));
        pending_reqs.push_back(make_req(CMD_ADD, 4'd15, 32'd1, 1'b1));
        pending_reqs.push_back(make_req(CMD_TICK, 4'd0, '0, 1'b0));
        drain_queue();
        hold_until_drained = 1;

        for (k = 0; k < 410; k++) begin
            if (k % 100 == 0) begin
                drain_queue();
                case ((k / 100) % 4)
                    0: idle_pct = 0;
                    1: idle_pct = 63;
                    2: idle_pct = 25;
                    default: idle_pct = 0;
                endcase
            end
            pending_reqs.push_back(random_req());
        end
        drain_queue();
        stimulus_done = 1;
    end

    initial begin
        wait (stimulus_done);
        while (expected_beats.size() != 0 && cycle_count < 400000) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (cycle_count >= 400000) begin
            $display("[FAIL] regression broken");
        end else if (error_count == 0 && expected_beats.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        wait (cycle_count >= 400000);
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
